// ----- src/script_call_scanner_unit_assert.svh -----
// Assertion macros for the script call scanner.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef SCRIPT_CALL_SCANNER_UNIT_ASSERT_SVH
`define SCRIPT_CALL_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define SCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/scs_pkg.sv -----
// Types, codes and helpers shared by the script call scanner modules.
// No dependencies.
package scs_pkg;

    localparam int NAME_MAX = 4;   // name slots in the parser state
    localparam int MAX_EV   = 5;   // most events one text byte can cause

    // event codes
    localparam logic [2:0] EV_CALL       = 3'd0;
    localparam logic [2:0] EV_PARAM_BYTE = 3'd1;
    localparam logic [2:0] EV_PARAM_DONE = 3'd2;
    localparam logic [2:0] EV_CALL_DONE  = 3'd3;
    localparam logic [2:0] EV_TEXT_DONE  = 3'd4;

    // parse phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MATCH = 2'd1;
    localparam logic [1:0] PH_AWAIT = 2'd2;
    localparam logic [1:0] PH_PARAM = 2'd3;

    // line phases
    localparam logic [1:0] LP_LEAD    = 2'd0;
    localparam logic [1:0] LP_BODY    = 2'd1;
    localparam logic [1:0] LP_COMMENT = 2'd2;

    // characters
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] name_index;
        logic [7:0] byte_value;
        logic       clean_end;
        logic       last;
    } t_out_item;

    // events of one text byte
    typedef struct packed {
        t_out_item [MAX_EV-1:0] ev;
        logic [2:0]             cnt;
    } t_pkt;

    typedef struct packed {
        logic [1:0]                phase;
        logic                      param_open;
        logic [NAME_MAX-1:0]       live;
        logic [NAME_MAX-1:0][4:0]  pos;
    } t_pstate;

    function automatic t_pkt scs_emit(t_pkt e, logic [2:0] code, logic [1:0] idx,
                                      logic [7:0] b, logic clean);
        if (e.cnt < 3'(MAX_EV)) begin
            e.ev[e.cnt] = '{event_res: code, name_index: idx, byte_value: b,
                            clean_end: clean, last: 1'b0};
            e.cnt = e.cnt + 3'd1;
        end
        return e;
    endfunction

    function automatic logic scs_is_eol(logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

// ----- src/scs_front.sv -----
// Front end: name registers, line/comment tracking and call parser.
// Turns each text byte into a packet of events. Uses scs_pkg.
module scs_front import scs_pkg::*; #(
    parameter int NAME_COUNT = 4,
    parameter int NAME_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_ready,
    output logic        o_push,
    output t_pkt        o_pkt,
    input  logic        i_q_ready
);

    typedef logic [NAME_COUNT-1:0][127:0] t_name_set;

    typedef struct packed {
        t_pstate st;
        t_pkt    evs;
    } t_pres;

    t_name_set  r_name;
    logic [1:0] r_line, n_line;
    logic       r_eol, n_eol;
    logic       r_held, n_held;
    logic       r_mid, n_mid;
    t_pstate    r_ps, n_ps;
    t_pkt       w_evs;
    logic       w_acc;

    function automatic logic [7:0] name_byte(t_name_set nm, int i, logic [4:0] k);
        logic [7:0] r;
        r = '0;
        if (32'(k) < NAME_BYTES) r = nm[i][{k[3:0], 3'b000} +: 8];
        return r;
    endfunction

    function automatic t_pkt skip_b(t_pstate s, t_pkt e, logic [7:0] b);
        if (s.phase == PH_PARAM && s.param_open) e = scs_emit(e, EV_PARAM_BYTE, 2'd0, b, 1'b0);
        return e;
    endfunction

    function automatic t_pres parse_b(t_name_set nm, t_pstate s, t_pkt e, logic [7:0] b);
        t_pres      r;
        logic       passed;
        logic [7:0] c;
        logic [4:0] np;
        r.st = s;
        r.evs = e;
        passed = 1'b0;
        unique case (s.phase)
            PH_IDLE: begin
                if (b == CH_DOT || b == CH_COLON) begin
                    for (int i = 0; i < NAME_COUNT; i++) begin
                        r.st.pos[i] = '0;
                        r.st.live[i] = 1'b1;
                    end
                    r.st.phase = PH_MATCH;
                end
            end
            PH_MATCH: begin
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (s.live[i]) begin
                        c = name_byte(nm, i, s.pos[i]);
                        if (c != 8'd0 && c == b) begin
                            np = s.pos[i] + 5'd1;
                            r.st.pos[i] = np;
                            passed = 1'b1;
                            if (name_byte(nm, i, np) == 8'd0) begin
                                r.evs = scs_emit(r.evs, EV_CALL, 2'(i), 8'd0, 1'b0);
                                r.st.param_open = 1'b0;
                                r.st.phase = PH_AWAIT;
                            end
                        end else begin
                            r.st.live[i] = 1'b0;
                        end
                    end
                end
                if (!passed) r.st.phase = PH_IDLE;
            end
            PH_AWAIT: begin
                if (b == CH_LPAREN) r.st.phase = PH_PARAM;
            end
            PH_PARAM: begin
                if (b == CH_COMMA) begin
                    if (s.param_open) r.evs = scs_emit(r.evs, EV_PARAM_DONE, 2'd0, 8'd0, 1'b0);
                    r.st.param_open = 1'b0;
                end else if (b == CH_RPAREN) begin
                    if (s.param_open) r.evs = scs_emit(r.evs, EV_PARAM_DONE, 2'd0, 8'd0, 1'b0);
                    r.evs = scs_emit(r.evs, EV_CALL_DONE, 2'd0, 8'd0, 1'b0);
                    r.st.param_open = 1'b0;
                    r.st.phase = PH_IDLE;
                end else begin
                    r.st.param_open = 1'b1;
                    r.evs = scs_emit(r.evs, EV_PARAM_BYTE, 2'd0, b, 1'b0);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always_comb begin
        logic [7:0] b;
        logic       fin, done;
        t_pres      pr;
        b = i_in_item.text_byte;
        fin = i_in_item.end_of_text;
        done = 1'b0;
        n_line = r_line;
        n_eol = r_eol;
        n_held = r_held;
        n_mid = 1'b1;
        n_ps = r_ps;
        w_evs = '0;
        pr = '0;
        if (!r_mid && fin) begin
            w_evs = scs_emit(w_evs, EV_TEXT_DONE, 2'd0, 8'd0, 1'b1);
        end else begin
            if (n_line != LP_LEAD && n_eol && !scs_is_eol(b)) begin
                n_line = LP_LEAD;
                n_eol = 1'b0;
            end
            if (n_line == LP_COMMENT) begin
                w_evs = skip_b(n_ps, w_evs, b);
                if (scs_is_eol(b)) n_eol = 1'b1;
                done = 1'b1;
            end else if (n_line == LP_LEAD) begin
                if (n_held) begin
                    n_held = 1'b0;
                    if (b == CH_DASH) begin
                        w_evs = skip_b(n_ps, w_evs, CH_DASH);
                        w_evs = skip_b(n_ps, w_evs, CH_DASH);
                        n_line = LP_COMMENT;
                        n_eol = 1'b0;
                        done = 1'b1;
                    end else begin
                        pr = parse_b(r_name, n_ps, w_evs, CH_DASH);
                        n_ps = pr.st;
                        w_evs = pr.evs;
                        n_line = LP_BODY;
                    end
                end else if (b == CH_SPACE || b == CH_TAB) begin
                    w_evs = skip_b(n_ps, w_evs, b);
                    done = 1'b1;
                end else if (b == CH_DASH && !fin) begin
                    n_held = 1'b1;
                    done = 1'b1;
                end else begin
                    n_line = LP_BODY;
                end
            end
            if (!done) begin
                pr = parse_b(r_name, n_ps, w_evs, b);
                n_ps = pr.st;
                w_evs = pr.evs;
                if (scs_is_eol(b)) n_eol = 1'b1;
            end
            if (fin) begin
                w_evs = scs_emit(w_evs, EV_TEXT_DONE, 2'd0, 8'd0, n_ps.phase == PH_IDLE);
            end
        end
        if (fin) begin
            n_line = LP_LEAD;
            n_eol = 1'b0;
            n_held = 1'b0;
            n_mid = 1'b0;
            n_ps = '0;
        end
    end

    assign o_in_ready = i_q_ready;
    assign w_acc = i_in_valid && i_q_ready;
    assign o_push = i_in_valid && (w_evs.cnt != 3'd0);
    assign o_pkt = w_evs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name <= '0;
            r_line <= LP_LEAD;
            r_eol <= 1'b0;
            r_held <= 1'b0;
            r_mid <= 1'b0;
            r_ps <= '0;
        end else begin
            for (int i = 0; i < NAME_COUNT; i++) begin
                if (i_cfg_we && i_cfg_idx[2:1] == 2'(i)) begin
                    if (i_cfg_idx[0]) r_name[i][127:64] <= i_cfg_data;
                    else r_name[i][63:0] <= i_cfg_data;
                end
            end
            if (w_acc) begin
                r_line <= n_line;
                r_eol <= n_eol;
                r_held <= n_held;
                r_mid <= n_mid;
                r_ps <= n_ps;
            end
        end
    end

endmodule

// ----- src/scs_queue.sv -----
// Two-entry packet queue between front end and back end.
// Uses scs_pkg for the packet type.
module scs_queue import scs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    output logic o_ready,
    output logic o_valid,
    output t_pkt o_pkt,
    input  logic i_pop
);

    t_pkt       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       w_wen, w_ren;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_pkt = r_mem[r_rd];
    assign w_wen = i_push && o_ready;
    assign w_ren = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wen) r_mem[r_wr] <= i_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wen) r_wr <= ~r_wr;
            if (w_ren) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_wen) - 2'(w_ren);
        end
    end

endmodule

// ----- src/scs_back.sv -----
// Back end: unpacks event packets and hands out one result item a cycle while the output is ready.
// Uses scs_pkg.
module scs_back import scs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_pkt      i_q_pkt,
    output logic      o_q_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_ready
);

    t_pkt       r_pkt;
    logic       r_valid;
    logic [2:0] r_slot;
    logic       w_last, w_load;

    assign w_last = (r_slot == r_pkt.cnt - 3'd1);
    assign w_load = !r_valid || (i_out_ready && w_last);
    assign o_q_pop = w_load;
    assign o_out_valid = r_valid;

    always_comb begin
        o_out_item = r_pkt.ev[r_slot];
        o_out_item.last = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_q_valid) r_pkt <= i_q_pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot <= 3'd0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
            r_slot <= 3'd0;
        end else if (i_out_ready) begin
            r_slot <= r_slot + 3'd1;
        end
    end

endmodule

// ----- src/script_call_scanner_unit.sv -----
// Script call scanner: takes script text one byte per item and reports calls to up to
// NAME_COUNT configured names (dot or colon, name, '(' parameters ')'), their parameter
// bytes and ends, and a text-done item on the last byte. A byte is taken every cycle while
// the two-packet queue has room; each byte yields a packet of zero to five result items,
// which the back end hands out at one item per cycle while the output is ready, so input
// keeps pace unless a byte has several items or the output stalls. Name registers must be
// written through the plain write port while the block is idle; the block does not check.
// Uses scs_pkg, scs_front, scs_queue, scs_back.
module script_call_scanner_unit import scs_pkg::*; #(
    parameter int NAME_COUNT = 4,
    parameter int NAME_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    logic w_push, w_q_ready, w_q_valid, w_pop;
    t_pkt w_pkt_in, w_pkt_out;

    // front: classify bytes, track line and call state, build event packets
    scs_front #(.NAME_COUNT(NAME_COUNT), .NAME_BYTES(NAME_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_item(i_in_item), .o_in_ready(o_in_ready),
        .o_push(w_push), .o_pkt(w_pkt_in), .i_q_ready(w_q_ready)
    );

    // decoupling queue
    scs_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_pkt(w_pkt_in), .o_ready(w_q_ready),
        .o_valid(w_q_valid), .o_pkt(w_pkt_out), .i_pop(w_pop)
    );

    // back: one result item per cycle while the output is ready
    scs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_q_valid), .i_q_pkt(w_pkt_out), .o_q_pop(w_pop),
        .o_out_valid(o_out_valid), .o_out_item(o_out_item), .i_out_ready(i_out_ready)
    );

`include "script_call_scanner_unit_assert.svh"

    `SCS_ASSERT_NOW(a_push_room, w_push && o_in_ready, w_q_ready, "push into full queue")
    `SCS_ASSERT_NOW(a_ev_code, o_out_valid, o_out_item.event_res <= EV_TEXT_DONE, "bad event code")
    `SCS_ASSERT_NOW(a_call_idx, o_out_valid && o_out_item.event_res == EV_CALL, 32'(o_out_item.name_index) < NAME_COUNT, "call for unconfigured slot")
    `SCS_ASSERT_NEXT(a_text_idle, i_in_valid && o_in_ready && i_in_item.end_of_text, o_out_valid || w_q_valid, "text done lost")

endmodule

// ----- verif/scs_checker.sv -----
// Checker for the script call scanner: watches the config port and both item channels,
// predicts the result items of every accepted text byte and compares them in order.
// Depends on scs_pkg.
module scs_checker import scs_pkg::*; #(
    parameter int NAME_COUNT = 4,
    parameter int NAME_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int MAX_PER_BYTE = 10;

    logic [63:0] name_reg [8];
    logic [1:0]  line_ph;
    bit          eol_seen;
    bit          dash_held;
    bit          in_text;
    logic [1:0]  parse_ph;
    logic [4:0]  match_pos [4];
    bit          name_alive [4];
    bit          arg_open;

    t_out_item   byte_events [$];
    t_out_item   pending_results [$];
    int          fails;

    function automatic logic [7:0] name_char(int i, logic [4:0] k);
        if (k >= NAME_BYTES) return 8'h00;
        return name_reg[2 * i + (k >= 5'd8 ? 1 : 0)][8 * k[2:0] +: 8];
    endfunction

    function automatic bit eol_char(logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

    function void add_event(logic [2:0] code, logic [1:0] idx, logic [7:0] b, logic clean);
        t_out_item e;
        e.event_res  = code;
        e.name_index = idx;
        e.byte_value = b;
        e.clean_end  = clean;
        e.last       = 1'b0;
        if (byte_events.size() < MAX_PER_BYTE) byte_events.insert(byte_events.size(), e);
    endfunction

    function void clear_scan();
        line_ph   = LP_LEAD;
        eol_seen  = 0;
        dash_held = 0;
        parse_ph  = PH_IDLE;
        arg_open  = 0;
        in_text   = 0;
        for (int i = 0; i < 4; i++) begin
            match_pos[i]  = '0;
            name_alive[i] = 0;
        end
    endfunction

    // skipped bytes still count as parameter bytes inside an open parameter
    function void skipped(logic [7:0] b);
        if (parse_ph == PH_PARAM && arg_open) add_event(EV_PARAM_BYTE, 2'd0, b, 1'b0);
    endfunction

    function void parse_char(logic [7:0] b);
        int passed;
        logic [7:0] c;
        passed = 0;
        case (parse_ph)
            PH_IDLE: begin
                if (b == CH_DOT || b == CH_COLON) begin
                    for (int i = 0; i < NAME_COUNT; i++) begin
                        match_pos[i]  = '0;
                        name_alive[i] = 1;
                    end
                    parse_ph = PH_MATCH;
                end
            end
            PH_MATCH: begin
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (name_alive[i]) begin
                        c = name_char(i, match_pos[i]);
                        if (c != 8'h00 && c == b) begin
                            match_pos[i] = match_pos[i] + 5'd1;
                            passed++;
                            if (name_char(i, match_pos[i]) == 8'h00) begin
                                add_event(EV_CALL, 2'(i), 8'h00, 1'b0);
                                arg_open = 0;
                                parse_ph = PH_AWAIT;
                            end
                        end else begin
                            name_alive[i] = 0;
                        end
                    end
                end
                if (passed == 0) parse_ph = PH_IDLE;
            end
            PH_AWAIT: begin
                if (b == CH_LPAREN) parse_ph = PH_PARAM;
            end
            default: begin
                if (b == CH_COMMA) begin
                    if (arg_open) add_event(EV_PARAM_DONE, 2'd0, 8'h00, 1'b0);
                    arg_open = 0;
                end else if (b == CH_RPAREN) begin
                    if (arg_open) add_event(EV_PARAM_DONE, 2'd0, 8'h00, 1'b0);
                    add_event(EV_CALL_DONE, 2'd0, 8'h00, 1'b0);
                    arg_open = 0;
                    parse_ph = PH_IDLE;
                end else begin
                    arg_open = 1;
                    add_event(EV_PARAM_BYTE, 2'd0, b, 1'b0);
                end
            end
        endcase
    endfunction

    function void take_char(logic [7:0] b, bit fin);
        if (line_ph != LP_LEAD && eol_seen && !eol_char(b)) begin
            line_ph  = LP_LEAD;
            eol_seen = 0;
        end
        if (line_ph == LP_COMMENT) begin
            skipped(b);
            if (eol_char(b)) eol_seen = 1;
            return;
        end
        if (line_ph == LP_LEAD) begin
            if (dash_held) begin
                dash_held = 0;
                if (b == CH_DASH) begin
                    skipped(CH_DASH);
                    skipped(CH_DASH);
                    line_ph  = LP_COMMENT;
                    eol_seen = 0;
                    return;
                end
                parse_char(CH_DASH);
            end else if (b == CH_SPACE || b == CH_TAB) begin
                skipped(b);
                return;
            end else if (b == CH_DASH && !fin) begin
                dash_held = 1;
                return;
            end
            line_ph = LP_BODY;
        end
        parse_char(b);
        if (eol_char(b)) eol_seen = 1;
    endfunction

    function void predict_byte(t_in_item it);
        byte_events.delete();
        if (!in_text && it.end_of_text) begin
            add_event(EV_TEXT_DONE, 2'd0, 8'h00, 1'b1);
            clear_scan();
        end else begin
            in_text = 1;
            take_char(it.text_byte, it.end_of_text);
            if (it.end_of_text) begin
                add_event(EV_TEXT_DONE, 2'd0, 8'h00, parse_ph == PH_IDLE);
                clear_scan();
            end
        end
        if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
        foreach (byte_events[k]) pending_results.insert(pending_results.size(), byte_events[k]);
    endfunction

    initial begin
        fails = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int r = 0; r < 8; r++) name_reg[r] = '0;
            clear_scan();
            pending_results.delete();
        end else begin
            if (i_cfg_we) name_reg[i_cfg_idx] = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_byte(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    fails++;
                    $display("%0t: expected no item, actual ev=%0d idx=%0d byte=%02h clean=%0d last=%0d",
                             $time, i_out_item.event_res, i_out_item.name_index,
                             i_out_item.byte_value, i_out_item.clean_end, i_out_item.last);
                end else begin
                    want = pending_results.pop_front();
                    if (want.event_res  !== i_out_item.event_res  ||
                        want.name_index !== i_out_item.name_index ||
                        want.byte_value !== i_out_item.byte_value ||
                        want.clean_end  !== i_out_item.clean_end  ||
                        want.last       !== i_out_item.last) begin
                        fails++;
                        $display("%0t: expected ev=%0d idx=%0d byte=%02h clean=%0d last=%0d",
                                 $time, want.event_res, want.name_index, want.byte_value,
                                 want.clean_end, want.last);
                        $display("%0t: actual   ev=%0d idx=%0d byte=%02h clean=%0d last=%0d",
                                 $time, i_out_item.event_res, i_out_item.name_index,
                                 i_out_item.byte_value, i_out_item.clean_end,
                                 i_out_item.last);
                    end
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fails;
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the script call scanner testbench: clock, reset, name register setup and
// text stimulus, with scs_checker beside the block doing prediction and comparison.
// Depends on scs_pkg, scs_checker and script_call_scanner_unit.
module testbench;
    import scs_pkg::*;

    localparam int TEXT_ITEMS  = 100;  // random items per phase
    localparam int DRAIN_WAIT  = 16;   // pipeline settle before config writes / the end
    localparam int NAME_SLOTS  = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    int          fail_count;
    int          pending;

    int          idle_pct;   // chance the sender sits out a cycle
    int          stall_pct;  // chance the receiver holds ready low
    int          sent;
    string       names [NAME_SLOTS];

    script_call_scanner_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    scs_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, well beyond the slowest legal run
    initial begin
        #3000000;
        $display("script_call_scanner_unit: mismatch");
        $finish;
    end

    // receiver: random back-pressure at the phase's stall rate
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // eight bytes of a name, byte 0 lowest, zero-padded
    function automatic logic [63:0] name_word(string s, int base);
        logic [63:0] w;
        w = '0;
        for (int k = 0; k < 8; k++)
            if (base + k < s.len()) w[8 * k +: 8] = s[base + k];
        return w;
    endfunction

    // only once nothing is in flight; the sender drops valid first
    task automatic load_names();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        for (int r = 0; r < 8; r++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= 3'(r);
            cfg_data <= name_word(names[r / 2], (r % 2) * 8);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b, bit fin);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid            <= 1'b1;
        in_item.text_byte   <= b;
        in_item.end_of_text <= fin;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_text(logic [7:0] q [$]);
        foreach (q[k]) send_byte(q[k], k == q.size() - 1);
    endtask

    task automatic send_str(string s, bit fin);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], fin && k == s.len() - 1);
    endtask

    function automatic string rand_name();
        string s;
        s = "";
        repeat ($urandom_range(16, 1)) s = {s, string'(8'($urandom_range(122, 97)))};
        return s;
    endfunction

    function automatic logic [7:0] arg_char();
        case ($urandom_range(9))
            0:       return CH_SPACE;
            1:       return CH_DASH;
            2:       return 8'($urandom_range(255));
            default: return 8'($urandom_range(122, 97));
        endcase
    endfunction

    // one line of text: mostly well-formed calls, some comments and raw noise
    task automatic add_line(ref logic [7:0] q [$]);
        int kind;
        int slot;
        string nm;
        repeat ($urandom_range(2)) q.insert(q.size(), $urandom_range(1) ? CH_SPACE : CH_TAB);
        kind = $urandom_range(19);
        if (kind < 14) begin
            q.insert(q.size(), $urandom_range(1) ? CH_DOT : CH_COLON);
            slot = $urandom_range(NAME_SLOTS - 1);
            nm = names[slot];
            if (nm.len() == 0) nm = rand_name();
            // a cut-short name now and then, a broken call
            if ($urandom_range(9) == 0) nm = nm.substr(0, $urandom_range(nm.len() - 1));
            for (int k = 0; k < nm.len(); k++) q.insert(q.size(), nm[k]);
            repeat ($urandom_range(1)) q.insert(q.size(), CH_SPACE);
            q.insert(q.size(), CH_LPAREN);
            repeat ($urandom_range(3)) begin
                repeat ($urandom_range(4)) q.insert(q.size(), arg_char());
                // line break, sometimes with a comment, inside the parameter list
                if ($urandom_range(7) == 0) begin
                    q.insert(q.size(), CH_LF);
                    q.insert(q.size(), CH_TAB);
                    if ($urandom_range(1)) begin
                        q.insert(q.size(), CH_DASH);
                        q.insert(q.size(), CH_DASH);
                        q.insert(q.size(), arg_char());
                        q.insert(q.size(), CH_CR);
                        q.insert(q.size(), CH_LF);
                    end
                    q.insert(q.size(), arg_char());
                end
                q.insert(q.size(), CH_COMMA);
            end
            repeat ($urandom_range(3)) q.insert(q.size(), arg_char());
            if ($urandom_range(9) != 0) q.insert(q.size(), CH_RPAREN);
        end else if (kind < 17) begin
            q.insert(q.size(), CH_DASH);
            if ($urandom_range(3) != 0) q.insert(q.size(), CH_DASH);
            repeat ($urandom_range(5)) q.insert(q.size(), 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(6, 1)) q.insert(q.size(), 8'($urandom_range(255)));
        end
        case ($urandom_range(2))
            0: q.insert(q.size(), CH_LF);
            1: q.insert(q.size(), CH_CR);
            default: begin
                q.insert(q.size(), CH_CR);
                q.insert(q.size(), CH_LF);
            end
        endcase
    endtask

    task automatic random_texts(int quota);
        logic [7:0] q [$];
        int stop_at;
        stop_at = sent + quota;
        while (sent < stop_at) begin
            q.delete();
            if ($urandom_range(19) == 0) begin
                q.insert(q.size(), 8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(4, 1)) add_line(q);
                // sometimes the text stops mid-line
                if ($urandom_range(3) == 0) q.insert(q.size(), arg_char());
            end
            send_text(q);
        end
    endtask

    initial begin
        logic [7:0] q [$];
        idle_pct  = 0;
        stall_pct = 0;
        sent      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two names finishing on the same byte, one slot left empty, one full length
        names[0] = "foo";
        names[1] = "foo";
        names[2] = "";
        names[3] = "abcdefghijklmnop";
        load_names();

        // single-byte text: only the end report
        send_byte(8'h78, 1'b1);
        // blanks, a comment and an empty parameter while the call is open
        send_str(".foo(a\n\tb\n--c\r\nd,,)", 1'b1);
        // lone dash at line start, the longest name, zero and all-ones bytes, cut off
        send_str("-x:abcdefghijklmnop(", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        // a dash that is the last byte is parsed straight away
        send_str("a\n-", 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            if (ph == 1 || ph == 3) begin
                for (int s = 0; s < NAME_SLOTS; s++)
                    names[s] = (ph == 3 && $urandom_range(3) == 0) ? "" : rand_name();
                names[0] = rand_name();
                load_names();
            end else if (ph == 2) begin
                // every register all ones: four 16-byte names of 0xff
                for (int s = 0; s < NAME_SLOTS; s++) begin
                    names[s] = "";
                    repeat (16) names[s] = {names[s], string'(8'hff)};
                end
                load_names();
            end
            random_texts(TEXT_ITEMS);
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("script_call_scanner_unit: match");
        end else begin
            $display("script_call_scanner_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/scs_pkg.sv
src/scs_front.sv
src/scs_queue.sv
src/scs_back.sv
src/script_call_scanner_unit.sv
verif/scs_checker.sv
verif/testbench.sv
